// ----- design/mldf_pkg.sv -----
// Shared types, constants and magic-string lookup for the magic length-prefixed deframer.
`default_nettype none
package mldf_pkg;

   localparam int LENGTH_FIELD_BYTES_DEF = 8;
   localparam int BODY_COUNT_BITS_DEF    = 27;

   localparam int MAX_LEN_BITS = 27;
   localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 27'd100000000;

   localparam int MAGIC_POS_BITS = 5;
   localparam logic [MAGIC_POS_BITS-1:0] REQ_LEN = 5'd26;
   localparam logic [MAGIC_POS_BITS-1:0] RSP_LEN = 5'd28;

   localparam logic [26*8-1:0] REQ_MAGIC = "a6m1n 2 server request ~~~";
   localparam logic [28*8-1:0] RSP_MAGIC = "server to 4dm1n r3sponse ~~~";

   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_DONE = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_MESSAGE_KIND    = 1'b0,
      CSR_MAX_BODY_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type  frame_status;
      logic        body_valid;
      logic [7:0]  body_byte;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic kind,
                                             input logic [MAGIC_POS_BITS-1:0] pos);
      logic [7:0] b;
      b = '0;
      if (kind) begin
         if (pos < RSP_LEN) begin
            b = RSP_MAGIC[(27 - int'(pos)) * 8 +: 8];
         end
      end else begin
         if (pos < REQ_LEN) begin
            b = REQ_MAGIC[(25 - int'(pos)) * 8 +: 8];
         end
      end
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- design/magic_length_prefixed_deframer_unit.sv -----
// Top level of the magic length-prefixed deframer.
//
//   channel   ports                                   direction
//   req       req_valid/req_stall, req_in_byte        in
//   rsp       rsp_valid/rsp_stall, rsp_frame_status,  out
//             rsp_body_valid, rsp_body_byte
//   csr       csr_we, csr_index, csr_wdata            in
//
// One byte per cycle sustained while rsp is not stalled; each req byte is registered in
// the input register, then passes through parse logic into the result register, which
// drives rsp.
// Parser state advances only when the input register moves into the result register.
// A stalled rsp holds the result register; req then stalls once the input register is full.
// Synchronous reset clears parser state, valid flags and the configuration registers.
`default_nettype none
module magic_length_prefixed_deframer_unit
   import mldf_pkg::*;
#(
   parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF,
   parameter int BODY_COUNT_BITS    = BODY_COUNT_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_in_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_frame_status,
   output logic                         rsp_body_valid,
   output logic [7:0]                   rsp_body_byte,
   input  wire logic                    csr_we,
   input  wire logic [0:0]              csr_index,
   input  wire logic [MAX_LEN_BITS-1:0] csr_wdata
);

   logic                    kind_ff;
   logic [MAX_LEN_BITS-1:0] max_len_ff;
   logic                    advance;
   logic                    stage_valid;
   logic [7:0]              stage_byte;
   result_type              parse_result;
   result_type              rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= 1'b0;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MESSAGE_KIND:    kind_ff    <= csr_wdata[0];
            CSR_MAX_BODY_LENGTH: max_len_ff <= csr_wdata;
            default:             ;
         endcase
      end
   end

   mldf_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_byte  (stage_byte)
   );

   mldf_parse #(
      .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES),
      .BODY_COUNT_BITS    (BODY_COUNT_BITS)
   ) u_parse (
      .clock           (clock),
      .reset           (reset),
      .message_kind    (kind_ff),
      .max_body_length (max_len_ff),
      .fire            (stage_valid && advance),
      .in_byte         (stage_byte),
      .result          (parse_result)
   );

   mldf_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid),
      .in_result  (parse_result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_frame_status = rsp_result.frame_status;
   assign rsp_body_valid   = rsp_result.body_valid;
   assign rsp_body_byte    = rsp_result.body_byte;

endmodule
`default_nettype wire

// ----- design/mldf_in_stage.sv -----
// Input register stage: captures one received byte per transfer.
`default_nettype none
module mldf_in_stage
   import mldf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       advance,
   output logic            stage_valid,
   output logic [7:0]      stage_byte
);

   logic       valid_ff;
   logic [7:0] byte_ff;

   assign req_stall   = valid_ff && !advance;
   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
      end
   end

endmodule
`default_nettype wire

// ----- design/mldf_parse.sv -----
// Frame parser: magic check, length gathering, body counting and final status.
`default_nettype none
module mldf_parse
   import mldf_pkg::*;
#(
   parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF,
   parameter int BODY_COUNT_BITS    = BODY_COUNT_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    message_kind,
   input  wire logic [MAX_LEN_BITS-1:0] max_body_length,
   input  wire logic                    fire,
   input  wire logic [7:0]              in_byte,
   output result_type                   result
);

   localparam int DLW  = 8 * LENGTH_FIELD_BYTES;
   localparam int LBW  = $clog2(LENGTH_FIELD_BYTES + 1);
   localparam int MCW  = (DLW > MAX_LEN_BITS) ? DLW : MAX_LEN_BITS;
   localparam int BCW  = (DLW > BODY_COUNT_BITS) ? DLW : BODY_COUNT_BITS;
   localparam logic [LBW-1:0] LB_LAST = LBW'(LENGTH_FIELD_BYTES);
   localparam logic [BODY_COUNT_BITS-1:0] BODY_MAX = '1;

   logic [MAGIC_POS_BITS-1:0]  pos_ff, pos_in;
   logic [LBW-1:0]             lbs_ff, lbs_in;
   logic [DLW-1:0]             dl_ff, dl_in;
   logic [BODY_COUNT_BITS-1:0] cnt_ff, cnt_in;
   status_type                 status_ff, status_in;

   logic [MAGIC_POS_BITS-1:0]  mlen;
   logic [DLW+7:0]             dl_shift;

   always_comb begin
      mlen      = message_kind ? RSP_LEN : REQ_LEN;
      dl_shift  = {dl_ff, in_byte};
      pos_in    = pos_ff;
      lbs_in    = lbs_ff;
      dl_in     = dl_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      result.body_valid = 1'b0;
      result.body_byte  = '0;
      if (status_ff == ST_BUSY) begin
         priority if (pos_ff < mlen) begin
            if (magic_byte(message_kind, pos_ff) != in_byte) begin
               status_in = ST_ERR;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end else if (lbs_ff < LB_LAST) begin
            dl_in  = dl_shift[DLW-1:0];
            lbs_in = lbs_ff + 1'b1;
            if (lbs_in == LB_LAST) begin
               if (MCW'(dl_in) > MCW'(max_body_length)) begin
                  status_in = ST_ERR;
               end else if (dl_in == '0) begin
                  status_in = ST_DONE;
               end
            end
         end else begin
            result.body_valid = 1'b1;
            result.body_byte  = in_byte;
            if (cnt_ff != BODY_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if ((BCW'(cnt_in) >= BCW'(dl_ff)) || (cnt_in == BODY_MAX)) begin
               status_in = ST_DONE;
            end
         end
      end
      result.frame_status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         lbs_ff    <= '0;
         dl_ff     <= '0;
         cnt_ff    <= '0;
         status_ff <= ST_BUSY;
      end else if (fire) begin
         pos_ff    <= pos_in;
         lbs_ff    <= lbs_in;
         dl_ff     <= dl_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/mldf_out_stage.sv -----
// Result register stage: holds one result until the consumer takes it.
`default_nettype none
module mldf_out_stage
   import mldf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  result_type      in_result,
   output logic            advance,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      rsp_result
);

   logic       valid_ff;
   result_type result_ff;

   assign advance    = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && advance) begin
         result_ff <= in_result;
      end
   end

endmodule
`default_nettype wire

// ----- design/mldf_checker.sv -----
// Port-level assertions for the deframer top level, with its bind.
`default_nettype none
module mldf_checker
   import mldf_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_frame_status,
   input wire logic       rsp_body_valid,
   input wire logic [7:0] rsp_body_byte
);

   logic       fin_ff;
   logic [1:0] fin_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff        <= 1'b0;
         fin_status_ff <= ST_BUSY;
      end else if (rsp_valid && !rsp_stall && !fin_ff && rsp_frame_status != ST_BUSY) begin
         fin_ff        <= 1'b1;
         fin_status_ff <= rsp_frame_status;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_body_valid) && $stable(rsp_body_byte))
      else $error("stalled result changed");

   a_final_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fin_ff |-> rsp_frame_status == fin_status_ff && !rsp_body_valid)
      else $error("result after final status differs");

   a_body_not_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_valid |-> rsp_frame_status != ST_ERR)
      else $error("body byte carries error status");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_body_valid |-> rsp_body_byte == 8'd0)
      else $error("non-body result has nonzero byte");

endmodule

bind magic_length_prefixed_deframer_unit mldf_checker u_mldf_checker (.*);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the magic length-prefixed deframer: directed frame plus random body.
module tb;
   import mldf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned LONG_HOLD_MARK = 300;
   localparam int unsigned LONG_HOLD_SPAN = 120;
   localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_ALL_ONES = '1;
   localparam logic [BODY_COUNT_BITS_DEF-1:0] BODY_ALL_ONES = '1;

   typedef enum logic {
      PLAN_CSR  = 1'b0,
      PLAN_BYTE = 1'b1
   } plan_op_type;

   typedef struct {
      plan_op_type               op;
      csr_index_type             idx;
      logic [MAX_LEN_BITS-1:0]   value;
      result_type                want;
   } plan_step_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [7:0]              req_in_byte;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_frame_status;
   logic                    rsp_body_valid;
   logic [7:0]              rsp_body_byte;
   logic                    csr_we;
   logic [0:0]              csr_index;
   logic [MAX_LEN_BITS-1:0] csr_wdata;

   // predictor copy of configuration and parser state
   logic                           cfg_kind    = 1'b0;
   logic [MAX_LEN_BITS-1:0]        cfg_max     = MAX_LEN_RESET;
   logic [MAGIC_POS_BITS-1:0]      mag_pos     = '0;
   logic [3:0]                     len_seen    = '0;
   logic [63:0]                    len_decl    = '0;
   logic [BODY_COUNT_BITS_DEF-1:0] body_seen   = '0;
   status_type                     frame_state = ST_BUSY;

   result_type    pending_results[$];
   plan_step_type frame_plan[$];
   bit            pinned_on;
   result_type    pinned_result;
   int unsigned   bytes_taken   = 0;
   int unsigned   results_taken = 0;
   int unsigned   error_count   = 0;
   int unsigned   cycle_count   = 0;

   magic_length_prefixed_deframer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_body_valid   (rsp_body_valid),
      .rsp_body_byte    (rsp_body_byte),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type r;
      logic [MAGIC_POS_BITS-1:0] mlen;
      logic [7:0] want;
      r = '0;
      mlen = cfg_kind ? RSP_LEN : REQ_LEN;
      if (frame_state == ST_BUSY) begin
         if (mag_pos < mlen) begin
            want = cfg_kind ? RSP_MAGIC[(int'(RSP_LEN) - 1 - int'(mag_pos)) * 8 +: 8]
                            : REQ_MAGIC[(int'(REQ_LEN) - 1 - int'(mag_pos)) * 8 +: 8];
            if (want != b) begin
               frame_state = ST_ERR;
            end else begin
               mag_pos = mag_pos + 5'd1;
            end
         end else if (len_seen < LENGTH_FIELD_BYTES_DEF) begin
            len_decl = {len_decl[55:0], b};
            len_seen = len_seen + 4'd1;
            if (len_seen == LENGTH_FIELD_BYTES_DEF) begin
               if (len_decl > 64'(cfg_max)) begin
                  frame_state = ST_ERR;
               end else if (len_decl == 64'd0) begin
                  frame_state = ST_DONE;
               end
            end
         end else begin
            r.body_valid = 1'b1;
            r.body_byte  = b;
            if (body_seen != BODY_ALL_ONES) begin
               body_seen = body_seen + 1'b1;
            end
            if (64'(body_seen) >= len_decl || body_seen == BODY_ALL_ONES) begin
               frame_state = ST_DONE;
            end
         end
      end
      r.frame_status = frame_state;
      return r;
   endfunction

   function automatic result_type mk_result(input status_type s, input logic v,
                                            input logic [7:0] d);
      result_type r;
      r.frame_status = s;
      r.body_valid   = v;
      r.body_byte    = d;
      return r;
   endfunction

   function automatic int unsigned idle_span(input bit steady);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type model;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_MESSAGE_KIND) begin
               cfg_kind = csr_wdata[0];
            end else begin
               cfg_max = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t unexpected transfer: expected none, actual status %0d %0d %0d",
                        $time, rsp_frame_status, rsp_body_valid, rsp_body_byte);
            end else begin
               want = pending_results.pop_front();
               check_field("frame_status", want.frame_status, rsp_frame_status);
               check_field("body_valid", want.body_valid, rsp_body_valid);
               check_field("body_byte", want.body_byte, rsp_body_byte);
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            model = deframe_byte(req_in_byte);
            pending_results.push_back(pinned_on ? pinned_result : model);
         end
      end
   end

   // receiver: random stall stretches plus one long hold-off
   initial begin : rsp_side
      int unsigned hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && bytes_taken >= LONG_HOLD_MARK) begin
            held      = 1'b1;
            hold_left = LONG_HOLD_SPAN;
         end else if (hold_left == 0) begin
            hold_left = idle_span((results_taken / 250) % 3 == 1);
         end
         rsp_stall = (hold_left != 0);
         if (hold_left != 0) hold_left--;
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type want);
      int unsigned gap;
      int unsigned seen;
      gap = idle_span((bytes_taken / 300) % 3 == 2);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_in_byte   = b;
      pinned_on     = typed;
      pinned_result = want;
      seen          = bytes_taken;
      do @(negedge clock); while (bytes_taken == seen);
   endtask

   task automatic wait_frame_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [MAX_LEN_BITS-1:0] v);
      wait_frame_idle();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic void add_byte(input logic [7:0] b, input result_type want);
      plan_step_type s;
      s.op    = PLAN_BYTE;
      s.idx   = CSR_MESSAGE_KIND;
      s.value = MAX_LEN_BITS'(b);
      s.want  = want;
      frame_plan.push_back(s);
   endfunction

   function automatic void add_csr(input csr_index_type idx,
                                   input logic [MAX_LEN_BITS-1:0] v);
      plan_step_type s;
      s.op    = PLAN_CSR;
      s.idx   = idx;
      s.value = v;
      s.want  = '0;
      frame_plan.push_back(s);
   endfunction

   initial begin : req_side
      int unsigned body_len;
      int          i;
      result_type  busy;
      plan_step_type s;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      csr_we      = 1'b0;
      csr_index   = CSR_MESSAGE_KIND;
      csr_wdata   = '0;
      pinned_on   = 1'b0;
      pinned_result = '0;
      body_len = $urandom_range(1690, 1730);
      busy     = mk_result(ST_BUSY, 1'b0, 8'h00);

      // request magic, then switch kind so the last two bytes come from the response magic
      add_csr(CSR_MESSAGE_KIND, {26'($urandom), 1'b0});
      add_csr(CSR_MAX_BODY_LENGTH, '0);
      for (i = 0; i < int'(REQ_LEN); i++) begin
         add_byte(REQ_MAGIC[(int'(REQ_LEN) - 1 - i) * 8 +: 8], busy);
      end
      add_csr(CSR_MESSAGE_KIND, {26'($urandom), 1'b1});
      add_byte(RSP_MAGIC[(int'(RSP_LEN) - 1 - int'(REQ_LEN)) * 8 +: 8], busy);
      add_byte(RSP_MAGIC[(int'(RSP_LEN) - 2 - int'(REQ_LEN)) * 8 +: 8], busy);
      add_csr(CSR_MESSAGE_KIND, {26'($urandom), 1'b0});
      add_csr(CSR_MAX_BODY_LENGTH, MAX_LEN_ALL_ONES);
      for (i = 0; i < 7; i++) begin
         add_byte(8'(64'(body_len) >> (8 * (7 - i))), busy);
      end
      add_csr(CSR_MAX_BODY_LENGTH, MAX_LEN_BITS'(body_len));
      add_byte(8'(body_len), busy);
      add_byte(8'h00, mk_result(ST_BUSY, 1'b1, 8'h00));
      add_byte(8'hFF, mk_result(ST_BUSY, 1'b1, 8'hFF));
      add_byte(8'h55, mk_result(ST_BUSY, 1'b1, 8'h55));
      add_byte(8'hAA, mk_result(ST_BUSY, 1'b1, 8'hAA));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (frame_plan.size() != 0) begin
         s = frame_plan.pop_front();
         if (s.op == PLAN_CSR) begin
            write_csr(s.idx, s.value);
         end else begin
            send_byte(s.value[7:0], 1'b1, s.want);
         end
      end

      for (i = 0; i < int'(body_len) - 4; i++) begin
         if (i == int'(body_len) / 3) begin
            write_csr(CSR_MESSAGE_KIND, MAX_LEN_BITS'($urandom));
         end
         if (i == int'(body_len) / 2) begin
            wait_frame_idle();
         end
         if (i == 2 * int'(body_len) / 3) begin
            write_csr(CSR_MAX_BODY_LENGTH, MAX_LEN_BITS'($urandom));
         end
         send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end

      // frame is complete: further bytes are still taken and answered with done status and no body byte
      send_byte(8'hFF, 1'b1, mk_result(ST_DONE, 1'b0, 8'h00));
      send_byte(8'h00, 1'b1, mk_result(ST_DONE, 1'b0, 8'h00));
      write_csr(CSR_MAX_BODY_LENGTH, '0);
      for (i = 0; i < 10; i++) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end

      wait_frame_idle();
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/mldf_pkg.sv
design/mldf_in_stage.sv
design/mldf_parse.sv
design/mldf_out_stage.sv
design/magic_length_prefixed_deframer_unit.sv
design/mldf_checker.sv
verif/tb.sv
